@@ sv/biquad_cascade_with_coefficient_ramp_assert.svh @@
// assertion macros shared by the biquad cascade rtl
`ifndef BIQUAD_CASCADE_WITH_COEFFICIENT_RAMP_ASSERT_SVH
`define BIQUAD_CASCADE_WITH_COEFFICIENT_RAMP_ASSERT_SVH

// same-cycle implication
`define BQC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqc assertion failed");

// next-cycle implication
`define BQC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqc assertion failed");

`endif

@@ sv/bqc_pkg.sv @@
// shared types and constants of the biquad cascade
package bqc_pkg;
   localparam int SAMPLE_W = 24;
   localparam int COEF_W = 32;
   localparam int DELAY_W = 48;
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int DIFF_W = COEF_W + 1;
   localparam int FRAMES_W = 16;
   localparam int CHAN_W = 2;
   localparam int FUNC_W = 2;
   localparam int SEC_IDX_W = 4;
   localparam int COEF_IDX_W = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int COEFS_PER_SECTION = 5;

   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RAMP_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

   localparam logic [FRAMES_W-1:0] RAMP_LENGTH_RESET = 16'd960;
   localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET = 2'd2;

   typedef struct packed {
      logic                start;
      logic [DIFF_W-1:0]   dividend;
      logic [FRAMES_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIFF_W-1:0] quotient;
   } div_status_type;
endpackage

@@ sv/bqc_if.sv @@
// request and response channel interfaces
interface bqc_req_if;
   import bqc_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [FUNC_W-1:0]            func;
   logic signed [SAMPLE_W-1:0]   left_in;
   logic signed [SAMPLE_W-1:0]   right_in;
   logic [SEC_IDX_W-1:0]         section_index;
   logic [COEF_IDX_W-1:0]        coeff_index;
   logic signed [COEF_W-1:0]     coeff_value;
   modport source (output valid, func, left_in, right_in, section_index, coeff_index,
                   coeff_value, input ready);
   modport sink (input valid, func, left_in, right_in, section_index, coeff_index,
                 coeff_value, output ready);
endinterface

interface bqc_rsp_if;
   import bqc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ sv/biquad_cascade_with_coefficient_ramp.sv @@
// biquad cascade top level: sequencer, shared multiplier and state memories
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        func, samples, coefficient write
//   rsp_chan  out   valid/ready        left_out, right_out
//   csr       in    csr_we             csr_index, csr_data
//
// a sample frame runs through every section for each filtered channel,
// and during a ramp each coefficient is first updated through the bit-serial divider
// a commit copies the pending bank into the target bank (bank copy)
// after reset a clearing pass runs with ready low
// a waiting result does not block the next transfer; a frame holds at its end
// until the result register is free
module biquad_cascade_with_coefficient_ramp #(
   parameter int NUM_SECTIONS = 16,
   parameter int NUM_CHANNELS = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   bqc_req_if.sink                        req_chan,
   bqc_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [bqc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bqc_pkg::CSR_DATA_W-1:0] csr_data
);
   import bqc_pkg::*;
   `include "biquad_cascade_with_coefficient_ramp_assert.svh"

   localparam int BANK = NUM_SECTIONS * COEFS_PER_SECTION;
   localparam int CA_W = $clog2(BANK);
   localparam int CNT_W = $clog2(BANK + 1);
   localparam int DD = NUM_SECTIONS * NUM_CHANNELS;
   localparam int DA_W = (DD > 1) ? $clog2(DD) : 1;
   localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_COMMIT   = 4'd2;
   localparam logic [3:0] ST_RAMP_RD  = 4'd3;
   localparam logic [3:0] ST_RAMP_DIV = 4'd4;
   localparam logic [3:0] ST_RAMP_WR  = 4'd5;
   localparam logic [3:0] ST_LOAD     = 4'd6;
   localparam logic [3:0] ST_MAC      = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sd8388607;
      lo = -34'sd8388608;
      if (v > hi) return SAMPLE_W'(hi);
      if (v < lo) return SAMPLE_W'(lo);
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [48:0] v);
      if (v[48] != v[47]) return v[48] ? {1'b1, {(DELAY_W-1){1'b0}}}
                                       : {1'b0, {(DELAY_W-1){1'b1}}};
      return v[DELAY_W-1:0];
   endfunction

   logic [3:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [2:0]                 step_ff, step_in;
   logic [SEC_W-1:0]           sec_ff, sec_in;
   logic                       ch_ff, ch_in;
   logic                       stereo_ff, stereo_in;
   logic [FRAMES_W-1:0]        frames_ff, frames_in;
   logic [FRAMES_W-1:0]        ramp_len_ff, ramp_len_in;
   logic [CHAN_W-1:0]          chan_cnt_ff, chan_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [SAMPLE_W-1:0] right_ff, right_in_r;
   logic signed [SAMPLE_W-1:0] left_res_ff, left_res_in;
   logic signed [COEF_W-1:0]   c_ff [COEFS_PER_SECTION];
   logic signed [COEF_W-1:0]   c_in [COEFS_PER_SECTION];
   logic signed [DELAY_W-1:0]  z1_ff, z1_in;
   logic signed [DELAY_W-1:0]  z2_ff, z2_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W:0]     acc_ff, acc_in;
   logic signed [COEF_W-1:0]   cur_ff, cur_in;
   logic                       neg_ff, neg_in;

   logic signed [COEF_W-1:0]   mul_a;
   logic signed [SAMPLE_W-1:0] mul_b;

   logic                       cur_we, tgt_we, pend_we, z1_we, z2_we;
   logic [CA_W-1:0]            cur_addr, tgt_addr, pend_addr;
   logic [DA_W-1:0]            dly_addr;
   logic [COEF_W-1:0]          cur_wdata, tgt_wdata, pend_wdata;
   logic [COEF_W-1:0]          cur_rdata, tgt_rdata, pend_rdata;
   logic [DELAY_W-1:0]         z1_wdata, z2_wdata, z1_rdata, z2_rdata;

   div_req_type                div_req;
   div_status_type             div_status;

   logic                       in_xfer;
   logic                       wr_ok;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [48:0]         wide;
   logic signed [48:0]         z1_sum;
   logic signed [PROD_W:0]     z2_diff;
   logic signed [DIFF_W:0]     q_signed;
   logic signed [DIFF_W:0]     cur_sum;

   assign in_xfer = req_chan.valid && req_chan.ready;
   assign wr_ok = (int'(req_chan.section_index) < NUM_SECTIONS) &&
                  (int'(req_chan.coeff_index) < COEFS_PER_SECTION);

   // one shared multiplier, operands picked by the mac step
   always_comb begin
      mul_a = c_ff[0];
      mul_b = x_ff;
      case (step_ff)
         3'd0: begin mul_a = c_ff[0]; mul_b = x_ff; end
         3'd1: begin mul_a = c_ff[1]; mul_b = x_ff; end
         3'd2: begin mul_a = c_ff[3]; mul_b = y_ff; end
         3'd3: begin mul_a = c_ff[2]; mul_b = x_ff; end
         3'd4: begin mul_a = c_ff[4]; mul_b = y_ff; end
         default: begin mul_a = c_ff[0]; mul_b = x_ff; end
      endcase
   end
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign diff = DIFF_W'($signed(tgt_rdata)) - DIFF_W'($signed(cur_rdata));
   assign wide = 49'(prod_ff >>> 15) + 49'(z1_ff);
   assign z1_sum = 49'(acc_ff >>> 15) + 49'(z2_ff);
   assign z2_diff = acc_ff - (PROD_W+1)'(prod_ff);
   assign q_signed = neg_ff ? -$signed({1'b0, div_status.quotient})
                            : $signed({1'b0, div_status.quotient});
   assign cur_sum = (DIFF_W+1)'(cur_ff) + q_signed;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      sec_in = sec_ff;
      ch_in = ch_ff;
      stereo_in = stereo_ff;
      frames_in = frames_ff;
      ramp_len_in = ramp_len_ff;
      chan_cnt_in = chan_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      x_in = x_ff;
      y_in = y_ff;
      right_in_r = right_ff;
      left_res_in = left_res_ff;
      c_in = c_ff;
      z1_in = z1_ff;
      z2_in = z2_ff;
      acc_in = acc_ff;
      cur_in = cur_ff;
      neg_in = neg_ff;

      cur_we = 1'b0;
      tgt_we = 1'b0;
      pend_we = 1'b0;
      z1_we = 1'b0;
      z2_we = 1'b0;
      cur_addr = cnt_ff[CA_W-1:0];
      tgt_addr = cnt_ff[CA_W-1:0];
      pend_addr = cnt_ff[CA_W-1:0];
      dly_addr = DA_W'(int'(ch_ff) * NUM_SECTIONS + int'(sec_ff));
      cur_wdata = '0;
      tgt_wdata = '0;
      pend_wdata = '0;
      z1_wdata = '0;
      z2_wdata = '0;
      div_req.start = 1'b0;
      div_req.dividend = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      div_req.divisor = frames_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_we) begin
         case (csr_index)
            REG_RAMP_LENGTH: ramp_len_in = csr_data;
            REG_CHANNEL_COUNT: chan_cnt_in = csr_data[CHAN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            cur_we = 1'b1;
            tgt_we = 1'b1;
            pend_we = 1'b1;
            z1_we = int'(cnt_ff) < DD;
            z2_we = int'(cnt_ff) < DD;
            dly_addr = cnt_ff[DA_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BANK - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            pend_addr = CA_W'(int'(req_chan.section_index) * COEFS_PER_SECTION +
                              int'(req_chan.coeff_index));
            pend_wdata = req_chan.coeff_value;
            if (in_xfer) begin
               case (req_chan.func)
                  FUNC_WRITE: pend_we = wr_ok;
                  FUNC_COMMIT: begin
                     cnt_in = '0;
                     state_in = ST_COMMIT;
                  end
                  FUNC_SAMPLE: begin
                     x_in = req_chan.left_in;
                     right_in_r = req_chan.right_in;
                     stereo_in = (NUM_CHANNELS >= 2) && (chan_cnt_ff >= 2'd2);
                     cnt_in = '0;
                     step_in = '0;
                     sec_in = '0;
                     ch_in = 1'b0;
                     state_in = (frames_ff != '0) ? ST_RAMP_RD : ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_COMMIT: begin
            // read pending one entry ahead of the target write
            tgt_addr = CA_W'(cnt_ff - 1'b1);
            tgt_we = cnt_ff != '0;
            tgt_wdata = pend_rdata;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(BANK)) begin
               frames_in = (ramp_len_ff != '0) ? ramp_len_ff : FRAMES_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_RAMP_RD: begin
            step_in = '0;
            state_in = ST_RAMP_DIV;
         end
         ST_RAMP_DIV: begin
            if (step_ff == 3'd0) begin
               cur_in = $signed(cur_rdata);
               neg_in = diff[DIFF_W-1];
               div_req.start = 1'b1;
               step_in = 3'd1;
            end else if (div_status.done) begin
               state_in = ST_RAMP_WR;
            end
         end
         ST_RAMP_WR: begin
            cur_we = 1'b1;
            cur_wdata = cur_sum[COEF_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            step_in = '0;
            if (cnt_ff == CNT_W'(BANK - 1)) begin
               frames_in = frames_ff - 1'b1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_RAMP_RD;
            end
         end
         ST_LOAD: begin
            cur_addr = CA_W'(int'(sec_ff) * COEFS_PER_SECTION + int'(step_ff));
            if (step_ff != 3'd0) begin
               c_in[step_ff - 3'd1] = $signed(cur_rdata);
            end
            if (step_ff == 3'd1) begin
               z1_in = $signed(z1_rdata);
               z2_in = $signed(z2_rdata);
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               step_in = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: y_in = sat24(34'(wide >>> 15));
               3'd2: acc_in = (PROD_W+1)'(prod_ff);
               3'd3: acc_in = acc_ff - (PROD_W+1)'(prod_ff);
               3'd4: begin
                  z1_we = 1'b1;
                  z1_wdata = sat48(z1_sum);
                  acc_in = (PROD_W+1)'(prod_ff);
               end
               3'd5: begin
                  z2_we = 1'b1;
                  z2_wdata = DELAY_W'(z2_diff >>> 15);
                  step_in = '0;
                  x_in = y_ff;
                  state_in = ST_LOAD;
                  if (sec_ff == SEC_W'(NUM_SECTIONS - 1)) begin
                     sec_in = '0;
                     if (!ch_ff) begin
                        left_res_in = y_ff;
                        if (stereo_ff) begin
                           ch_in = 1'b1;
                           x_in = right_ff;
                        end else begin
                           state_in = ST_DONE;
                        end
                     end else begin
                        right_in_r = y_ff;
                        state_in = ST_DONE;
                     end
                  end else begin
                     sec_in = sec_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in = left_res_ff;
               rsp_right_in = right_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
         step_ff <= '0;
         frames_ff <= '0;
         ramp_len_ff <= RAMP_LENGTH_RESET;
         chan_cnt_ff <= CHANNEL_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         step_ff <= step_in;
         frames_ff <= frames_in;
         ramp_len_ff <= ramp_len_in;
         chan_cnt_ff <= chan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sec_ff <= sec_in;
      ch_ff <= ch_in;
      stereo_ff <= stereo_in;
      rsp_left_ff <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      x_ff <= x_in;
      y_ff <= y_in;
      right_ff <= right_in_r;
      left_res_ff <= left_res_in;
      c_ff <= c_in;
      z1_ff <= z1_in;
      z2_ff <= z2_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      cur_ff <= cur_in;
      neg_ff <= neg_in;
   end

   bqc_ram #(.WIDTH(COEF_W), .DEPTH(BANK)) u_cur_ram (
      .clock(clock), .we(cur_we), .addr(cur_addr), .wdata(cur_wdata), .rdata(cur_rdata)
   );
   bqc_ram #(.WIDTH(COEF_W), .DEPTH(BANK)) u_tgt_ram (
      .clock(clock), .we(tgt_we), .addr(tgt_addr), .wdata(tgt_wdata), .rdata(tgt_rdata)
   );
   bqc_ram #(.WIDTH(COEF_W), .DEPTH(BANK)) u_pend_ram (
      .clock(clock), .we(pend_we), .addr(pend_addr), .wdata(pend_wdata),
      .rdata(pend_rdata)
   );
   bqc_ram #(.WIDTH(DELAY_W), .DEPTH(DD)) u_z1_ram (
      .clock(clock), .we(z1_we), .addr(dly_addr), .wdata(z1_wdata), .rdata(z1_rdata)
   );
   bqc_ram #(.WIDTH(DELAY_W), .DEPTH(DD)) u_z2_ram (
      .clock(clock), .we(z2_we), .addr(dly_addr), .wdata(z2_wdata), .rdata(z2_rdata)
   );

   bqc_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .status(div_status)
   );

   assign req_chan.ready = state_ff == ST_IDLE;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.left_out = rsp_left_ff;
   assign rsp_chan.right_out = rsp_right_ff;

   // a sample frame keeps the block busy on the next cycle
   `BQC_ASSERT_NEXT(a_frame_busy, clock, reset,
                    in_xfer && (req_chan.func == FUNC_SAMPLE), !req_chan.ready)
   // results appear only from the end of a frame
   `BQC_ASSERT_IMPLY(a_rsp_from_done, clock, reset,
                     $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   // the ramp counter is only ever raised by a commit
   `BQC_ASSERT_IMPLY(a_frames_commit, clock, reset,
                     frames_ff > $past(frames_ff), $past(state_ff) == ST_COMMIT)
endmodule

@@ sv/bqc_ram.sv @@
// generic single port ram with registered read
module bqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 80,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ sv/bqc_div.sv @@
// restoring divider, one quotient bit per cycle
module bqc_div (
   input  logic                    clock,
   input  logic                    reset,
   input  bqc_pkg::div_req_type    req,
   output bqc_pkg::div_status_type status
);
   import bqc_pkg::*;

   localparam int CNT_W = $clog2(DIFF_W);

   logic [FRAMES_W-1:0] rem_ff, rem_in;
   logic [DIFF_W-1:0]   quo_ff, quo_in;
   logic [FRAMES_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [FRAMES_W:0]   trial;
   logic                fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIFF_W-1]};
      fits = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         den_in = req.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? FRAMES_W'(trial - {1'b0, den_ff}) : trial[FRAMES_W-1:0];
         quo_in = {quo_ff[DIFF_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIFF_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.done = done_ff;
   assign status.quotient = quo_ff;
endmodule
